FILE: design/cdo_pkg.sv
// Shared types and constants of the Chebyshev differential operator.
package cdo_pkg;

	localparam int MAX_TERMS_DEF = 32;
	localparam int OUT_LIMIT     = 32;
	localparam int VAL_W         = 32;
	localparam int RES_W         = 64;
	localparam int IDX_W         = 5;
	localparam int CFG_IDX_W     = 2;

	localparam logic signed [VAL_W-1:0] GAIN_SECOND_RST = 32'sd65536;
	localparam logic signed [VAL_W-1:0] GAIN_FIRST_RST  = -32'sd262144;
	localparam logic signed [VAL_W-1:0] GAIN_ZERO_RST   = 32'sd262144;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_SECOND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_FIRST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_ZERO   = 2'd2;

	typedef struct packed {
		logic start;
		logic clear;
	} eng_ctl_t;

	typedef struct packed {
		logic                    we;
		logic                    done;
		logic                    sat;
		logic signed [RES_W-1:0] value;
	} eng_out_t;

endpackage

FILE: design/cdo_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cdo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/cdo_engine.sv
// Per-term arithmetic: suffix sums, derivative terms, gain products, saturation.
module cdo_engine import cdo_pkg::*; #(
	parameter int AW = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  eng_ctl_t                ctl,
	input  logic [AW-1:0]           n,
	input  logic signed [VAL_W-1:0] coef,
	input  logic signed [VAL_W-1:0] gain_d,
	input  logic signed [VAL_W-1:0] gain_e,
	input  logic signed [VAL_W-1:0] gain_f,
	output eng_out_t                res
);

	typedef enum logic [3:0] {
		ST_SEC_LO, ST_SEC_HI, ST_D_LO, ST_D_HI, ST_E_LO, ST_E_HI, ST_F, ST_S1, ST_S3
	} step_t;

	step_t                    step_q;
	logic                     busy_q;
	logic                     phase_q;
	logic [AW-1:0]            n_q;
	logic signed [VAL_W-1:0]  a_q;
	logic [2*AW-1:0]          n2_q;
	logic [3*AW-1:0]          n3_q;
	logic signed [65:0]       prod_q;
	logic signed [127:0]      acc_q;
	logic signed [RES_W-1:0]  sec_q;
	logic signed [RES_W-1:0]  s1_q [2];
	logic signed [RES_W-1:0]  s3_q [2];
	eng_out_t                 res_q;

	logic                     par;
	logic signed [RES_W-1:0]  s1_same;
	logic signed [RES_W-1:0]  s1_oth;
	logic signed [RES_W-1:0]  s3_same;
	logic signed [RES_W-1:0]  first;
	logic signed [32:0]       mx;
	logic signed [32:0]       my;
	logic signed [127:0]      prod_x;
	logic signed [127:0]      prod_sh;
	logic signed [127:0]      acc_f;
	logic                     sat;
	logic signed [RES_W-1:0]  sat_val;

	assign par     = n_q[0];
	assign s1_same = s1_q[par];
	assign s1_oth  = s1_q[~par];
	assign s3_same = s3_q[par];
	assign first   = s1_oth <<< 1;
	assign prod_x  = 128'(prod_q);
	assign prod_sh = prod_x <<< 32;
	assign acc_f   = (n_q == '0) ? (acc_q >>> 1) : acc_q;
	assign sat     = !((&acc_q[127:63]) || !(|acc_q[127:63]));
	assign sat_val = sat ? (acc_q[127] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}})
	                     : acc_q[RES_W-1:0];

	always_comb begin
		mx = '0;
		my = '0;
		case (step_q)
			ST_SEC_LO: begin mx = 33'(n2_q); my = {1'b0, s1_same[31:0]}; end
			ST_SEC_HI: begin mx = 33'(n2_q); my = {s1_same[63], s1_same[63:32]}; end
			ST_D_LO:   begin mx = 33'(gain_d); my = {1'b0, acc_q[31:0]}; end
			ST_D_HI:   begin mx = 33'(gain_d); my = {sec_q[63], sec_q[63:32]}; end
			ST_E_LO:   begin mx = 33'(gain_e); my = {1'b0, first[31:0]}; end
			ST_E_HI:   begin mx = 33'(gain_e); my = {first[63], first[63:32]}; end
			ST_F:      begin mx = 33'(gain_f); my = 33'(a_q); end
			ST_S1:     begin mx = 33'(n_q); my = 33'(a_q); end
			ST_S3:     begin mx = 33'(n3_q); my = 33'(a_q); end
			default:   begin mx = '0; my = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			phase_q   <= 1'b0;
			step_q    <= ST_SEC_LO;
			res_q.we  <= 1'b0;
			res_q.done <= 1'b0;
			s1_q[0]   <= '0;
			s1_q[1]   <= '0;
			s3_q[0]   <= '0;
			s3_q[1]   <= '0;
		end else begin
			res_q.we   <= 1'b0;
			res_q.done <= 1'b0;
			n3_q       <= n2_q * n_q;
			if (ctl.clear) begin
				s1_q[0] <= '0;
				s1_q[1] <= '0;
				s3_q[0] <= '0;
				s3_q[1] <= '0;
			end
			if (ctl.start) begin
				n_q     <= n;
				a_q     <= coef;
				n2_q    <= n * n;
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				step_q  <= ST_SEC_LO;
			end else if (busy_q) begin
				if (!phase_q) begin
					prod_q  <= mx * my;
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					unique case (step_q)
						ST_SEC_LO: begin
							acc_q  <= 128'(s3_same) - prod_x;
							step_q <= ST_SEC_HI;
						end
						ST_SEC_HI: begin
							acc_q  <= acc_q - prod_sh;
							step_q <= ST_D_LO;
						end
						ST_D_LO: begin
							sec_q  <= acc_q[RES_W-1:0];
							acc_q  <= prod_x;
							step_q <= ST_D_HI;
						end
						ST_D_HI: begin
							acc_q  <= acc_q + prod_sh;
							step_q <= ST_E_LO;
						end
						ST_E_LO: begin
							acc_q  <= acc_q + prod_x;
							step_q <= ST_E_HI;
						end
						ST_E_HI: begin
							acc_q  <= acc_q + prod_sh;
							step_q <= ST_F;
						end
						ST_F: begin
							acc_q  <= acc_f + prod_x;
							step_q <= ST_S1;
						end
						ST_S1: begin
							res_q.we    <= 1'b1;
							res_q.sat   <= sat;
							res_q.value <= sat_val;
							s1_q[par]   <= s1_same + prod_q[RES_W-1:0];
							step_q      <= ST_S3;
						end
						ST_S3: begin
							s3_q[par]  <= s3_same + prod_q[RES_W-1:0];
							res_q.done <= 1'b1;
							busy_q     <= 1'b0;
							step_q     <= ST_SEC_LO;
						end
						default: step_q <= ST_SEC_LO;
					endcase
				end
			end
		end
	end

	assign res = res_q;

endmodule

FILE: design/chebyshev_diff_operator.sv
// Top level of the Chebyshev differential operator in coefficient space.
// Coefficients are loaded one per cycle into a coefficient RAM; the marked
// last coefficient starts a backward pass over the stored terms, from the
// highest index down, that keeps running suffix sums by parity and forms each
// result with one shared 33x33 multiplier (nine products per term). Each
// term's coefficient is read from the coefficient RAM before the engine
// starts on it; each result is read back from the result RAM, registered
// and held while the output is stalled. New coefficients are taken only
// once the last result of the previous vector has transferred. Results
// land in a 32-entry result RAM and are emitted in rising index.
module chebyshev_diff_operator import cdo_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    coef_valid,
	output logic                    coef_stall,
	input  logic signed [VAL_W-1:0] coef_value,
	input  logic                    last_coef,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [RES_W-1:0] result_value,
	output logic [IDX_W-1:0]        result_index,
	output logic                    last_result,
	output logic                    overflow,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [VAL_W-1:0]        cfg_data
);

	localparam int AW = $clog2(MAX_TERMS);
	localparam int CW = $clog2(MAX_TERMS + 1);

	typedef enum logic [2:0] {
		S_LOAD, S_RD, S_WAIT, S_CALC, S_ERD, S_EWAIT, S_EOUT
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           count_q;
	logic                    drop_q;
	logic                    flag_all_q;
	logic [AW-1:0]           n_q;
	logic [IDX_W-1:0]        e_q;
	logic signed [VAL_W-1:0] gain_d_q;
	logic signed [VAL_W-1:0] gain_e_q;
	logic signed [VAL_W-1:0] gain_f_q;
	logic                    out_valid_q;
	logic signed [RES_W-1:0] out_value_q;
	logic [IDX_W-1:0]        out_index_q;
	logic                    out_last_q;
	logic                    out_ovf_q;

	logic                    coef_xfer;
	logic                    store;
	logic [CW-1:0]           count_nx;
	logic [IDX_W:0]          emit;
	logic                    e_last;
	logic [VAL_W-1:0]        coef_rdata;
	logic [RES_W:0]          res_rdata;
	logic                    res_we;
	eng_ctl_t                eng_ctl;
	eng_out_t                eng_res;

	assign coef_stall = (state_q != S_LOAD);
	assign coef_xfer  = coef_valid && !coef_stall;
	assign store      = coef_xfer && (cnt_q < CW'(MAX_TERMS));
	assign count_nx   = store ? cnt_q + 1'b1 : cnt_q;
	assign emit       = (7'(count_q) > 7'(OUT_LIMIT)) ? (IDX_W+1)'(OUT_LIMIT)
	                                                  : (IDX_W+1)'(count_q);
	assign e_last     = ((IDX_W+1)'(e_q) + 1'b1) == emit;
	assign res_we     = eng_res.we && (7'(n_q) < 7'(OUT_LIMIT));
	assign cfg_ready  = 1'b1;

	assign eng_ctl.start = (state_q == S_WAIT);
	assign eng_ctl.clear = (state_q == S_LOAD);

	cdo_ram #(.WIDTH(VAL_W), .DEPTH(MAX_TERMS)) u_coef_ram (
		.clk   (clk),
		.we    (store),
		.waddr (cnt_q[AW-1:0]),
		.wdata (coef_value),
		.raddr (n_q),
		.rdata (coef_rdata)
	);

	cdo_ram #(.WIDTH(RES_W + 1), .DEPTH(OUT_LIMIT)) u_res_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (IDX_W'(n_q)),
		.wdata ({eng_res.sat, eng_res.value}),
		.raddr (e_q),
		.rdata (res_rdata)
	);

	cdo_engine #(.AW(AW)) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (eng_ctl),
		.n      (n_q),
		.coef   (coef_rdata),
		.gain_d (gain_d_q),
		.gain_e (gain_e_q),
		.gain_f (gain_f_q),
		.res    (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_d_q <= GAIN_SECOND_RST;
			gain_e_q <= GAIN_FIRST_RST;
			gain_f_q <= GAIN_ZERO_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_SECOND: gain_d_q <= cfg_data;
				REG_GAIN_FIRST:  gain_e_q <= cfg_data;
				REG_GAIN_ZERO:   gain_f_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			count_q     <= '0;
			drop_q      <= 1'b0;
			flag_all_q  <= 1'b0;
			n_q         <= '0;
			e_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (coef_xfer) begin
						cnt_q <= count_nx;
						if (!store) begin
							drop_q <= 1'b1;
						end
						if (last_coef) begin
							count_q    <= count_nx;
							flag_all_q <= !store || drop_q
							              || (7'(count_nx) > 7'(OUT_LIMIT));
							n_q        <= AW'(count_nx - 1'b1);
							state_q    <= S_RD;
						end
					end
				end
				S_RD:   state_q <= S_WAIT;
				S_WAIT: state_q <= S_CALC;
				S_CALC: begin
					if (eng_res.done) begin
						if (n_q == '0) begin
							e_q     <= '0;
							state_q <= S_ERD;
						end else begin
							n_q     <= n_q - 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_ERD:  state_q <= S_EWAIT;
				S_EWAIT: begin
					out_valid_q <= 1'b1;
					out_value_q <= res_rdata[RES_W-1:0];
					out_ovf_q   <= res_rdata[RES_W] || flag_all_q;
					out_index_q <= e_q;
					out_last_q  <= e_last;
					state_q     <= S_EOUT;
				end
				S_EOUT: begin
					if (!result_stall) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							e_q     <= e_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result_value = out_value_q;
	assign result_index = out_index_q;
	assign last_result  = out_last_q;
	assign overflow     = out_ovf_q;

endmodule

FILE: design/cdo_checker.sv
// Port-level checks of the Chebyshev differential operator, bound to the top.
module cdo_checker import cdo_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    coef_valid,
	input logic                    coef_stall,
	input logic                    result_valid,
	input logic                    result_stall,
	input logic signed [RES_W-1:0] result_value,
	input logic [IDX_W-1:0]        result_index,
	input logic                    last_result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_value)
		&& $stable(result_index))
		else $error("stalled result changed");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && !coef_stall |-> !result_valid)
		else $error("coefficient taken while a result is pending");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && last_result |=> !result_valid && !coef_stall)
		else $error("vector did not end after last result");

endmodule

bind chebyshev_diff_operator cdo_checker u_cdo_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.coef_valid   (coef_valid),
	.coef_stall   (coef_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_value (result_value),
	.result_index (result_index),
	.last_result  (last_result)
);
